>>> rtl/core/gha_pkg.sv
// Package for the generational handle allocator: request and status codes,
// beat structs, controller state and command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package gha_pkg;

  // Request codes
  localparam logic [1:0] REQ_ALLOC    = 2'd0;
  localparam logic [1:0] REQ_RELEASE  = 2'd1;
  localparam logic [1:0] REQ_VALIDATE = 2'd2;

  // Result status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_INVALID = 2'd1;
  localparam logic [1:0] STS_FULL    = 2'd2;

  // Fixed field widths of a handle
  localparam int HIDX_W = 8;
  localparam int HGEN_W = 16;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [HIDX_W-1:0] handle_index;
    logic [HGEN_W-1:0] handle_generation;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [HIDX_W-1:0] out_index;
    logic [HGEN_W-1:0] out_generation;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FETCH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;          // capture request, issue first memory reads
    logic fetch;         // issue generation read at popped slot
    logic finish_lookup; // complete request from first reads
    logic finish_fetch;  // complete allocate of a recycled slot
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_fetch;    // allocate with a non-empty free stack
  } dp_sts_t;

endpackage

>>> rtl/core/gha_ctrl.sv
// Controller of the generational handle allocator: sequences each request.
// Depends on gha_pkg.
`timescale 1ns / 1ps

module gha_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  gha_pkg::dp_sts_t sts,
  output logic            busy,
  output gha_pkg::dp_cmd_t cmd
);

  gha_pkg::state_t state_r;
  gha_pkg::state_t state_nxt;

  // Hold state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gha_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gha_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = gha_pkg::ST_LOOKUP;
        end
      end
      gha_pkg::ST_LOOKUP: begin
        state_nxt = sts.need_fetch ? gha_pkg::ST_FETCH : gha_pkg::ST_IDLE;
      end
      gha_pkg::ST_FETCH: begin
        state_nxt = gha_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = gha_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands and busy
  always_comb begin
    busy = 1'b1;
    cmd  = '0;
    unique case (state_r)
      gha_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      gha_pkg::ST_LOOKUP: begin
        cmd.fetch         = sts.need_fetch;
        cmd.finish_lookup = !sts.need_fetch;
      end
      gha_pkg::ST_FETCH: begin
        cmd.finish_fetch = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/core/gha_dp.sv
// Datapath of the generational handle allocator: slot and free-stack memories,
// counters, handle check and result register. Depends on gha_pkg.
`timescale 1ns / 1ps

module gha_dp #(
  parameter int SLOTS    = 256,
  parameter int GEN_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gha_pkg::dp_cmd_t   cmd,
  input  gha_pkg::in_beat_t  in_item,
  output gha_pkg::dp_sts_t   sts,
  output logic               out_valid,
  output gha_pkg::out_beat_t out_item
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (CNT_W > gha_pkg::HIDX_W) ? CNT_W : gha_pkg::HIDX_W;
  localparam int OIX_W = (IDX_W > gha_pkg::HIDX_W) ? IDX_W : gha_pkg::HIDX_W;
  localparam int GCM_W = (GEN_BITS > gha_pkg::HGEN_W) ? GEN_BITS : gha_pkg::HGEN_W;
  localparam int WRD_W = GEN_BITS + 1;  // alive flag over generation

  // Slot word: alive in the top bit. Entries at or above slots_used may be read but fail the range check.
  logic [WRD_W-1:0] slot_mem [SLOTS];
  logic [IDX_W-1:0] stack_mem [SLOTS];

  gha_pkg::in_beat_t req_r;
  logic [CNT_W-1:0]  slots_used_r, slots_used_nxt;
  logic [CNT_W-1:0]  free_count_r, free_count_nxt;
  logic [WRD_W-1:0]  slot_q_r;
  logic [IDX_W-1:0]  stack_q_r;
  logic              out_valid_r, out_valid_nxt;
  gha_pkg::out_beat_t out_item_r, out_item_nxt;

  logic [IDX_W-1:0] slot_rd_addr;
  logic [IDX_W-1:0] stack_rd_addr;
  logic [CNT_W-1:0] fc_dec;
  logic             slot_we;
  logic [IDX_W-1:0] slot_wa;
  logic [WRD_W-1:0] slot_wd;
  logic             stack_we;
  logic [CMP_W-1:0] req_idx_ext;
  logic [CMP_W-1:0] in_idx_ext;
  logic [IDX_W-1:0] req_addr;
  logic             in_range;
  logic             gen_match;
  logic             handle_ok;
  logic [GEN_BITS-1:0] stored_gen;
  logic [OIX_W-1:0] new_idx_ext;
  logic [OIX_W-1:0] pop_idx_ext;
  logic [GCM_W-1:0] pop_gen_ext;

  assign in_idx_ext    = CMP_W'(in_item.handle_index);
  assign req_idx_ext   = CMP_W'(req_r.handle_index);
  assign req_addr      = req_idx_ext[IDX_W-1:0];
  assign fc_dec        = free_count_r - CNT_W'(1);
  assign stack_rd_addr = fc_dec[IDX_W-1:0];
  assign slot_rd_addr  = cmd.fetch ? stack_q_r : in_idx_ext[IDX_W-1:0];
  assign stored_gen    = slot_q_r[GEN_BITS-1:0];

  // Check handle against slot word
  assign in_range  = req_idx_ext < CMP_W'(slots_used_r);
  assign gen_match = GCM_W'(stored_gen) == GCM_W'(req_r.handle_generation);
  assign handle_ok = in_range && slot_q_r[GEN_BITS] && gen_match;

  assign new_idx_ext = OIX_W'(slots_used_r[IDX_W-1:0]);
  assign pop_idx_ext = OIX_W'(stack_q_r);
  assign pop_gen_ext = GCM_W'(stored_gen);

  assign sts.need_fetch = (req_r.req_type == gha_pkg::REQ_ALLOC) &&
                          (free_count_r != '0);

  // Capture request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_item;
    end
  end

  // Slot memory: registered read, one write port
  always_ff @(posedge clk) begin
    if (cmd.load || cmd.fetch) begin
      slot_q_r <= slot_mem[slot_rd_addr];
    end
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
  end

  // Free stack memory: read top on load, push on release
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stack_q_r <= stack_mem[stack_rd_addr];
    end
    if (stack_we) begin
      stack_mem[free_count_r[IDX_W-1:0]] <= req_addr;
    end
  end

  // Finish a request: memory writes, counters, result
  always_comb begin
    slot_we        = 1'b0;
    slot_wa        = req_addr;
    slot_wd        = '0;
    stack_we       = 1'b0;
    slots_used_nxt = slots_used_r;
    free_count_nxt = free_count_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;

    if (cmd.finish_lookup) begin
      out_valid_nxt               = 1'b1;
      out_item_nxt.status         = gha_pkg::STS_INVALID;
      out_item_nxt.out_index      = req_r.handle_index;
      out_item_nxt.out_generation = req_r.handle_generation;
      unique case (req_r.req_type)
        gha_pkg::REQ_ALLOC: begin
          // free stack is empty here: take a fresh slot
          if (slots_used_r < CNT_W'(SLOTS)) begin
            slot_we                     = 1'b1;
            slot_wa                     = slots_used_r[IDX_W-1:0];
            slot_wd                     = {1'b1, GEN_BITS'(1)};
            slots_used_nxt              = slots_used_r + CNT_W'(1);
            out_item_nxt.status         = gha_pkg::STS_OK;
            out_item_nxt.out_index      = new_idx_ext[gha_pkg::HIDX_W-1:0];
            out_item_nxt.out_generation = gha_pkg::HGEN_W'(1);
          end else begin
            out_item_nxt.status = gha_pkg::STS_FULL;
          end
        end
        gha_pkg::REQ_RELEASE: begin
          if (handle_ok) begin
            slot_we             = 1'b1;
            slot_wd             = {1'b0, stored_gen + GEN_BITS'(1)};
            stack_we            = 1'b1;
            free_count_nxt      = free_count_r + CNT_W'(1);
            out_item_nxt.status = gha_pkg::STS_OK;
          end
        end
        gha_pkg::REQ_VALIDATE: begin
          if (handle_ok) begin
            out_item_nxt.status = gha_pkg::STS_OK;
          end
        end
        default: begin
          out_item_nxt.status = gha_pkg::STS_INVALID;
        end
      endcase
    end else if (cmd.finish_fetch) begin
      // recycled slot: mark alive, keep generation
      slot_we                     = 1'b1;
      slot_wa                     = stack_q_r;
      slot_wd                     = {1'b1, stored_gen};
      free_count_nxt              = fc_dec;
      out_valid_nxt               = 1'b1;
      out_item_nxt.status         = gha_pkg::STS_OK;
      out_item_nxt.out_index      = pop_idx_ext[gha_pkg::HIDX_W-1:0];
      out_item_nxt.out_generation = pop_gen_ext[gha_pkg::HGEN_W-1:0];
    end
  end

  // Counters and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_used_r <= '0;
      free_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      slots_used_r <= slots_used_nxt;
      free_count_r <= free_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> rtl/core/generational_handle_allocator_top.sv
// Channel   | ports                      | beat
// ----------+----------------------------+--------------------------------------
// request   | start, busy, in_item       | req_type, handle_index, handle_gen
// result    | out_valid, out_item        | status, out_index, out_generation
//
// A request is taken at an edge with start high and busy low. Busy then stays high
// through the lookup state, and through a fetch state as well for an allocate that
// reuses a freed slot: the free-stack read and the slot-word read each pass through
// a registered memory port. The result beat is registered at the edge that drops
// busy and sits on out_valid for one cycle, so the next request can be taken while
// out_valid is high. Reset (rst_n, synchronous) clears counters and control only;
// the receiver cannot stall.
// Depends on gha_pkg, gha_ctrl, gha_dp.
`timescale 1ns / 1ps

module generational_handle_allocator_top #(
  parameter int SLOTS    = 256,
  parameter int GEN_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  gha_pkg::in_beat_t  in_item,
  output logic               out_valid,
  output gha_pkg::out_beat_t out_item
);

  gha_pkg::dp_cmd_t cmd;
  gha_pkg::dp_sts_t sts;

  // Sequence requests
  gha_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Slot tables and result
  gha_dp #(
    .SLOTS    (SLOTS),
    .GEN_BITS (GEN_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

>>> tb/sv/gha_handle_checker.sv
// Result checker for the generational handle allocator: watches the request and
// result channels, predicts each result beat and compares it field by field.
// Depends on gha_pkg.
`timescale 1ns / 1ps

module gha_handle_checker #(
  parameter int SLOTS    = 256,
  parameter int GEN_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  gha_pkg::in_beat_t  in_item,
  input  logic               out_valid,
  input  gha_pkg::out_beat_t out_item,
  output int                 fail_count,
  output int                 backlog
);

  localparam int IDX_W = gha_pkg::HIDX_W;
  localparam int GEN_W = gha_pkg::HGEN_W;
  localparam logic [31:0] GEN_MASK = (GEN_BITS >= 32) ? 32'hFFFF_FFFF :
                                     ((32'd1 << GEN_BITS) - 32'd1);

  // Shadow copy of the slot table
  logic        slot_alive [SLOTS];
  logic [31:0] slot_gen   [SLOTS];
  int unsigned free_lifo  [SLOTS];
  int unsigned free_depth;
  int unsigned high_water;

  gha_pkg::out_beat_t expected_replies[$];
  int                 faults;

  function automatic bit handle_live(int unsigned idx, logic [GEN_W-1:0] gen);
    if (idx >= high_water || idx >= SLOTS) return 1'b0;
    return slot_alive[idx] && (slot_gen[idx] == 32'(gen));
  endfunction

  // Apply one request to the shadow table and return the reply it earns
  function automatic gha_pkg::out_beat_t serve_request(gha_pkg::in_beat_t req);
    gha_pkg::out_beat_t reply;
    int unsigned        slot;
    reply.status         = gha_pkg::STS_INVALID;
    reply.out_index      = req.handle_index;
    reply.out_generation = req.handle_generation;
    case (req.req_type)
      gha_pkg::REQ_ALLOC: begin
        if (free_depth > 0) begin
          // reuse the most recently freed slot
          free_depth--;
          slot = free_lifo[free_depth] % SLOTS;
          slot_alive[slot]     = 1'b1;
          reply.status         = gha_pkg::STS_OK;
          reply.out_index      = IDX_W'(slot);
          reply.out_generation = GEN_W'(slot_gen[slot]);
        end else if (high_water < SLOTS) begin
          // take a fresh slot, first generation is one
          slot = high_water;
          slot_gen[slot]       = 32'd1 & GEN_MASK;
          slot_alive[slot]     = 1'b1;
          high_water++;
          reply.status         = gha_pkg::STS_OK;
          reply.out_index      = IDX_W'(slot);
          reply.out_generation = GEN_W'(slot_gen[slot]);
        end else begin
          reply.status = gha_pkg::STS_FULL;
        end
      end
      gha_pkg::REQ_RELEASE: begin
        slot = req.handle_index;
        if (handle_live(slot, req.handle_generation) && free_depth < SLOTS) begin
          slot_alive[slot]      = 1'b0;
          slot_gen[slot]        = (slot_gen[slot] + 32'd1) & GEN_MASK;
          free_lifo[free_depth] = slot;
          free_depth++;
          reply.status = gha_pkg::STS_OK;
        end
      end
      gha_pkg::REQ_VALIDATE: begin
        if (handle_live(req.handle_index, req.handle_generation)) begin
          reply.status = gha_pkg::STS_OK;
        end
      end
      default: begin
        // unknown request: echo and leave the table alone
      end
    endcase
    return reply;
  endfunction

  always @(posedge clk) begin : watch
    gha_pkg::out_beat_t due;
    gha_pkg::out_beat_t predicted;
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) slot_alive[s] = 1'b0;
      free_depth = 0;
      high_water = 0;
      expected_replies.delete();
    end else begin
      // compare a result beat with the oldest prediction
      if (out_valid === 1'b1) begin
        if (expected_replies.size() == 0) begin
          $error("result beat with nothing expected: status %0d, out_index %0d, %s %0d",
                 out_item.status, out_item.out_index, "out_generation",
                 out_item.out_generation);
          faults++;
        end else begin
          due = expected_replies.pop_front();
          if (out_item.status !== due.status) begin
            $error("status: expected %0d, actual %0d", due.status, out_item.status);
            faults++;
          end
          if (out_item.out_index !== due.out_index) begin
            $error("out_index: expected %0d, actual %0d", due.out_index, out_item.out_index);
            faults++;
          end
          if (out_item.out_generation !== due.out_generation) begin
            $error("out_generation: expected %0d, actual %0d",
                   due.out_generation, out_item.out_generation);
            faults++;
          end
        end
      end
      // predict the reply for a request beat taken at this edge
      if (start === 1'b1 && busy === 1'b0) begin
        predicted        = serve_request(in_item);
        expected_replies = {expected_replies, predicted};
      end
    end
    fail_count <= faults;
    backlog    <= expected_replies.size();
  end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the generational handle allocator: drives directed and random
// requests with idle gaps and gives the verdict from the checker's failure count.
// Depends on gha_pkg, generational_handle_allocator_top, gha_handle_checker.
`timescale 1ns / 1ps

module tb;

  localparam int         IDX_W         = gha_pkg::HIDX_W;
  localparam int         GEN_W         = gha_pkg::HGEN_W;
  localparam int         IN_W          = $bits(gha_pkg::in_beat_t);
  localparam logic [1:0] REQ_UNDEFINED = 2'd3;
  localparam int         SOAK_ROUNDS   = 20;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } handle_t;

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               start   = 1'b0;
  gha_pkg::in_beat_t  in_item = '0;
  logic               busy;
  logic               out_valid;
  gha_pkg::out_beat_t out_item;
  int                 fail_count;
  int                 backlog;

  bit         gaps_on       = 1'b1;
  bit         track_handles = 1'b1;
  handle_t    live_handles[$];
  handle_t    stale_handles[$];
  logic [1:0] sent_kinds[$];

  always #2 clk = ~clk;

  generational_handle_allocator_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  gha_handle_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .fail_count(fail_count),
    .backlog   (backlog)
  );

  // Collect handles from successful allocations to aim later requests
  always @(posedge clk) begin : harvest
    logic [1:0] done_kind;
    handle_t    got;
    if (rst_n && start && !busy) sent_kinds = {sent_kinds, in_item.req_type};
    if (rst_n && out_valid && sent_kinds.size() > 0) begin
      done_kind = sent_kinds.pop_front();
      if (track_handles && done_kind == gha_pkg::REQ_ALLOC &&
          out_item.status == gha_pkg::STS_OK) begin
        got.idx      = out_item.out_index;
        got.gen      = out_item.out_generation;
        live_handles = {live_handles, got};
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Move a released handle from the live list to the stale list
  function automatic void forget_handle(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
    handle_t gone;
    gone.idx = idx;
    gone.gen = gen;
    for (int i = 0; i < live_handles.size(); i++) begin
      if (live_handles[i].idx == idx && live_handles[i].gen == gen) begin
        live_handles.delete(i);
        stale_handles = {stale_handles, gone};
        if (stale_handles.size() > 32) void'(stale_handles.pop_front());
        break;
      end
    end
  endfunction

  // Pick a handle: mostly live, else stale, off by one bit or random
  function automatic handle_t aim_handle();
    handle_t h;
    int      sel;
    sel   = $urandom_range(0, 9);
    h.idx = IDX_W'($urandom());
    h.gen = GEN_W'($urandom());
    if (sel < 7 && live_handles.size() > 0) begin
      h = live_handles[$urandom_range(0, live_handles.size() - 1)];
    end else if (sel < 8 && stale_handles.size() > 0) begin
      h = stale_handles[$urandom_range(0, stale_handles.size() - 1)];
    end else if (sel < 9 && live_handles.size() > 0) begin
      h = live_handles[$urandom_range(0, live_handles.size() - 1)];
      h.gen = h.gen ^ (GEN_W'(1) << $urandom_range(0, GEN_W - 1));
    end
    return h;
  endfunction

  // Present one request beat, hold it until taken, then maybe idle
  task automatic issue(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
                       input logic [GEN_W-1:0] gen);
    int pause;
    start   <= 1'b1;
    in_item <= '{req_type: kind, handle_index: idx, handle_generation: gen};
    @(posedge clk);
    while (busy) @(posedge clk);
    if (kind == gha_pkg::REQ_RELEASE) forget_handle(idx, gen);
    pause = gaps_on ? pick_gap() : 0;
    if (pause > 0) begin
      start   <= 1'b0;
      in_item <= gha_pkg::in_beat_t'(IN_W'($urandom()));
      repeat (pause) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
  endtask

  task automatic random_request();
    int      roll;
    handle_t h;
    roll = $urandom_range(0, 99);
    h    = aim_handle();
    if (roll < 38) issue(gha_pkg::REQ_ALLOC, IDX_W'($urandom()), GEN_W'($urandom()));
    else if (roll < 66) issue(gha_pkg::REQ_RELEASE, h.idx, h.gen);
    else if (roll < 94) issue(gha_pkg::REQ_VALIDATE, h.idx, h.gen);
    else issue(REQ_UNDEFINED, h.idx, h.gen);
  endtask

  initial begin : stimulus
    handle_t wrap_h;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fresh slots, stale and out-of-range handles, LIFO reuse
    issue(gha_pkg::REQ_ALLOC,    8'd7,   16'h1234);
    issue(gha_pkg::REQ_ALLOC,    8'hFF,  16'hFFFF);
    issue(gha_pkg::REQ_VALIDATE, 8'd0,   16'd1);
    issue(gha_pkg::REQ_VALIDATE, 8'd0,   16'd2);
    issue(gha_pkg::REQ_VALIDATE, 8'd0,   16'h8001);
    issue(gha_pkg::REQ_VALIDATE, 8'hFF,  16'hFFFF);
    issue(gha_pkg::REQ_VALIDATE, 8'd2,   16'd1);
    issue(gha_pkg::REQ_RELEASE,  8'd1,   16'd1);
    issue(gha_pkg::REQ_RELEASE,  8'd1,   16'd1);
    issue(gha_pkg::REQ_VALIDATE, 8'd1,   16'd2);
    issue(gha_pkg::REQ_RELEASE,  8'd0,   16'd0);
    issue(gha_pkg::REQ_ALLOC,    8'd0,   16'd0);
    issue(gha_pkg::REQ_VALIDATE, 8'd1,   16'd2);
    issue(gha_pkg::REQ_RELEASE,  8'd0,   16'd1);
    issue(gha_pkg::REQ_RELEASE,  8'd1,   16'd2);
    issue(gha_pkg::REQ_ALLOC,    8'hAA,  16'h5555);
    issue(gha_pkg::REQ_ALLOC,    8'h55,  16'hAAAA);
    issue(gha_pkg::REQ_ALLOC,    8'd0,   16'hFFFF);
    issue(REQ_UNDEFINED,         8'd0,   16'd0);
    issue(REQ_UNDEFINED,         8'hFF,  16'hFFFF);
    issue(gha_pkg::REQ_RELEASE,  8'd200, 16'd1);
    issue(gha_pkg::REQ_VALIDATE, 8'd0,   16'd0);
    settle();

    // Fill the table, then hit it while full with extreme fields
    gaps_on = 1'b0;
    repeat (253) issue(gha_pkg::REQ_ALLOC, IDX_W'($urandom()), GEN_W'($urandom()));
    gaps_on = 1'b1;
    issue(gha_pkg::REQ_ALLOC,    8'd0,  16'd0);
    issue(gha_pkg::REQ_ALLOC,    8'hFF, 16'hFFFF);
    issue(gha_pkg::REQ_VALIDATE, 8'hFF, 16'd1);
    settle();

    // Free about half the slots in random order to build a deep free stack
    while (live_handles.size() > 120) begin
      wrap_h = live_handles[$urandom_range(0, live_handles.size() - 1)];
      issue(gha_pkg::REQ_RELEASE, wrap_h.idx, wrap_h.gen);
    end

    // Random traffic, with idle-free stretches and an occasional full drain
    for (int n = 0; n < 320; n++) begin
      if (n % 50 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      random_request();
      if ($urandom_range(0, 199) == 0) settle();
    end
    settle();

    // Cycle one slot through release and reuse, checking new and old handles
    if (live_handles.size() == 0) begin
      issue(gha_pkg::REQ_ALLOC, 8'd0, 16'd0);
      settle();
    end
    wrap_h        = live_handles[0];
    track_handles = 1'b0;
    gaps_on       = 1'b0;
    for (int k = 0; k < SOAK_ROUNDS; k++) begin
      issue(gha_pkg::REQ_RELEASE, wrap_h.idx, wrap_h.gen);
      wrap_h.gen = wrap_h.gen + GEN_W'(1);
      issue(gha_pkg::REQ_ALLOC, IDX_W'($urandom()), GEN_W'($urandom()));
      issue(gha_pkg::REQ_VALIDATE, wrap_h.idx, wrap_h.gen);
      issue(gha_pkg::REQ_VALIDATE, wrap_h.idx, wrap_h.gen - GEN_W'(1));
    end

    settle();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs
  initial begin : watchdog
    #(1_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/gha_pkg.sv
rtl/core/gha_ctrl.sv
rtl/core/gha_dp.sv
rtl/core/generational_handle_allocator_top.sv
tb/sv/gha_handle_checker.sv
tb/sv/tb.sv
